[hdl/ctf_pkg.sv]
// Shared constants, types and tables of the complementary tilt filter.
// No dependencies; imported by every module of the block.
package ctf_pkg;

  // Sample, register and angle widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = SAMPLE_W + 2;
  localparam int unsigned ANGLE_W    = 25;
  localparam int unsigned DZ_W       = 15;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned WEIGHT_W   = 17;
  localparam int unsigned FORCE_W    = 17;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_PITCH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DZ_ROLL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_HIGH = 3'd5;

  // Register reset values
  localparam logic [DZ_W-1:0]     RST_DZ_PITCH   = 15'd10;
  localparam logic [DZ_W-1:0]     RST_DZ_ROLL    = 15'd25;
  localparam logic [GAIN_W-1:0]   RST_GYRO_GAIN  = 16'd152;
  localparam logic [WEIGHT_W-1:0] RST_ACC_WEIGHT = 17'd1311;
  localparam logic [FORCE_W-1:0]  RST_FORCE_LOW  = 17'd8192;
  localparam logic [FORCE_W-1:0]  RST_FORCE_HIGH = 17'd32768;

  // Angle format
  localparam int unsigned ANGLE_FRAC_BITS = 16;
  localparam int unsigned WEIGHT_FRAC     = 16;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;

  // Working precision of the integration and blend
  localparam int unsigned WORK_W  = 35;
  localparam int unsigned MUL_B_W = 18;
  localparam int unsigned PROD_W  = WORK_W + MUL_B_W;
  localparam longint      BLEND_RND = longint'(1) << (WEIGHT_FRAC - 1);

  // CORDIC
  localparam int unsigned CORDIC_STEPS  = 16;
  localparam int unsigned TAB_LEN       = 24;
  localparam int unsigned TAB_FRAC      = 20;
  localparam int unsigned COR_RUN       = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int unsigned STEP_W        = 5;
  localparam int unsigned COR_SCALE     = 14;
  localparam int unsigned COR_W         = SAMPLE_W + COR_SCALE + 3;
  localparam int unsigned ACC_W         = 29;
  localparam int unsigned RND_SH        = TAB_FRAC - ANGLE_FRAC_BITS;
  localparam longint      RND_HALF      = (RND_SH == 0) ? 0 : (longint'(1) << (RND_SH - 1));
  localparam longint      ACC_QUARTER   = longint'(90) << TAB_FRAC;

  // Wrap into [-180, 180): full turn is 45 << (ANGLE_FRAC_BITS + 3)
  localparam int unsigned WRAP_SH    = ANGLE_FRAC_BITS + 3;
  localparam longint      WRAP_FULL  = longint'(45) << WRAP_SH;
  localparam longint      WRAP_HALF  = longint'(45) << (WRAP_SH - 1);
  localparam longint      WRAP_BIAS  = WRAP_HALF + 93 * WRAP_FULL;
  localparam int unsigned U_W        = 33;
  localparam int unsigned N_W        = U_W - WRAP_SH;
  localparam int unsigned RECIP_SH   = 20;
  localparam int unsigned RECIP_W    = 15;
  localparam longint      RECIP_45   = ((longint'(1) << RECIP_SH) + 44) / 45;
  localparam int unsigned Q_W        = 8;

  // Request to the atan2 unit
  typedef struct packed {
    logic                       start;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] x;
  } cor_req_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [ACC_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
    case (idx)
      5'd0:    return ACC_W'(47185920);
      5'd1:    return ACC_W'(27855475);
      5'd2:    return ACC_W'(14718068);
      5'd3:    return ACC_W'(7471121);
      5'd4:    return ACC_W'(3750058);
      5'd5:    return ACC_W'(1876857);
      5'd6:    return ACC_W'(938658);
      5'd7:    return ACC_W'(469357);
      5'd8:    return ACC_W'(234682);
      5'd9:    return ACC_W'(117342);
      5'd10:   return ACC_W'(58671);
      5'd11:   return ACC_W'(29335);
      5'd12:   return ACC_W'(14668);
      5'd13:   return ACC_W'(7334);
      5'd14:   return ACC_W'(3667);
      5'd15:   return ACC_W'(1833);
      5'd16:   return ACC_W'(917);
      5'd17:   return ACC_W'(458);
      5'd18:   return ACC_W'(229);
      5'd19:   return ACC_W'(115);
      5'd20:   return ACC_W'(57);
      5'd21:   return ACC_W'(29);
      5'd22:   return ACC_W'(14);
      5'd23:   return ACC_W'(7);
      default: return '0;
    endcase
  endfunction

  // Magnitude of a raw sample, one bit wider
  function automatic logic [SAMPLE_W:0] mag_of(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W:0] e;
    e = (SAMPLE_W + 1)'(v);
    return v[SAMPLE_W-1] ? unsigned'(-e) : unsigned'(e);
  endfunction

endpackage

[hdl/ctf_mul.sv]
// Shared signed multiplier with registered product.
// Depends on ctf_pkg for operand widths.
module ctf_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [ctf_pkg::WORK_W-1:0]  a_i,
  input  logic signed [ctf_pkg::MUL_B_W-1:0] b_i,
  output logic signed [ctf_pkg::PROD_W-1:0]  prod_o
);
  import ctf_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // Capture the product when a transaction of the sequencer issues one
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

[hdl/ctf_cordic.sv]
// Iterative vectoring CORDIC giving atan2(y, x) in degrees, one step a cycle.
// Depends on ctf_pkg for the arctangent table and widths.
module ctf_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ctf_pkg::cor_req_t                  req_i,
  output logic                               done_o,
  output logic signed [ctf_pkg::ANGLE_W-1:0] angle_o
);
  import ctf_pkg::*;

  logic signed [COR_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [STEP_W-1:0]       cnt_q, cnt_d;
  logic                    run_q, run_d;
  logic                    done_q, done_d;

  logic signed [COR_W-1:0] xs, ys, sx, sy;
  logic signed [ACC_W-1:0] tab;
  logic signed [ACC_W-1:0] rnd;
  logic                    zero;

  // Load, pre-rotate into the right half plane, or iterate
  always_comb begin
    xs   = COR_W'(req_i.x) <<< COR_SCALE;
    ys   = COR_W'(req_i.y) <<< COR_SCALE;
    zero = (req_i.x == '0) && (req_i.y == '0);
    sx   = x_q >>> cnt_q;
    sy   = y_q >>> cnt_q;
    tab  = atan_entry(cnt_q);

    x_d    = x_q;
    y_d    = y_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    // Hold the done flag until the next start
    done_d = done_q;

    if (req_i.start) begin
      cnt_d  = '0;
      run_d  = !zero;
      done_d = zero;
      if (zero) begin
        x_d   = '0;
        y_d   = '0;
        acc_d = '0;
      end else if (xs[COR_W-1]) begin
        if (!ys[COR_W-1]) begin
          x_d   = ys;
          y_d   = -xs;
          acc_d = ACC_W'(ACC_QUARTER);
        end else begin
          x_d   = -ys;
          y_d   = xs;
          acc_d = -ACC_W'(ACC_QUARTER);
        end
      end else begin
        x_d   = xs;
        y_d   = ys;
        acc_d = '0;
      end
    end else if (run_q) begin
      if (!y_q[COR_W-1] && (y_q != '0)) begin
        x_d   = x_q + sy;
        y_d   = y_q - sx;
        acc_d = acc_q + tab;
      end else begin
        x_d   = x_q - sy;
        y_d   = y_q + sx;
        acc_d = acc_q - tab;
      end
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(COR_RUN - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold the datapath
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
  end

  // Step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // Round the accumulated angle to the output format
  assign rnd     = (acc_q + ACC_W'(RND_HALF)) >>> RND_SH;
  assign angle_o = ANGLE_W'(rnd);
  assign done_o  = done_q;

endmodule

[hdl/ctf_wrap.sv]
// Two-stage wrap of an unwrapped angle into [-180, 180) degrees.
// Depends on ctf_pkg; the modulo is a reciprocal multiply by 1/45 after a shift.
module ctf_wrap (
  input  logic                               clk_i,
  input  logic                               load_i,
  input  logic signed [ctf_pkg::WORK_W-1:0]  a_i,
  output logic signed [ctf_pkg::ANGLE_W-1:0] res_o
);
  import ctf_pkg::*;

  logic signed [WORK_W-1:0]    biased;
  logic [U_W-1:0]              u_d, u_q;
  logic [N_W-1:0]              turns_n;
  logic [N_W+RECIP_W-1:0]      q_full;
  logic [Q_W-1:0]              q_d, q_q;
  logic [U_W-1:0]              q_turn;
  logic [U_W-1:0]              rem;
  logic signed [ANGLE_W:0]     centred;

  // Stage one: bias positive, estimate the number of whole turns
  always_comb begin
    biased  = a_i + WORK_W'(WRAP_BIAS);
    u_d     = biased[U_W-1:0];
    turns_n = u_d[U_W-1:WRAP_SH];
    q_full  = (N_W + RECIP_W)'(turns_n) * (N_W + RECIP_W)'(RECIP_45);
    q_d     = q_full[RECIP_SH +: Q_W];
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      u_q <= u_d;
      q_q <= q_d;
    end
  end

  // Stage two: remove the whole turns and recentre
  always_comb begin
    q_turn  = U_W'(q_q) * U_W'(WRAP_FULL);
    rem     = u_q - q_turn;
    centred = $signed({1'b0, rem[ANGLE_W-1:0]}) - (ANGLE_W + 1)'(WRAP_HALF);
  end

  assign res_o = centred[ANGLE_W-1:0];

endmodule

[hdl/complementary_tilt_filter_top.sv]
// Top level of the complementary tilt filter: sequencer, registers, state.
// Depends on ctf_pkg, ctf_mul, ctf_cordic and ctf_wrap.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data_i| in
//  in      | in_valid_i in_ready_o accel_x/y/z gyro_x/z| in
//  out     | out_valid_o out_ready_i pitch/roll/applied| out
//
// With accelerometer correction, the two atan2 evaluations run one after the
// other through the shared CORDIC, 16 iterations each.
// Reset clears the angles to zero and loads the register defaults.
// A new sample is taken once the previous result has moved to the output
// register; a stalled output holds only the final write-back.
module complementary_tilt_filter_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ctf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ctf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0]   accel_x_i,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0]   accel_y_i,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0]   accel_z_i,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0]   gyro_x_i,
  input  logic signed [ctf_pkg::SAMPLE_W-1:0]   gyro_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [ctf_pkg::ANGLE_W-1:0]    pitch_out_o,
  output logic signed [ctf_pkg::ANGLE_W-1:0]    roll_out_o,
  output logic                                  accel_applied_o
);
  import ctf_pkg::*;

  localparam int unsigned ST_W = 4;
  localparam logic [ST_W-1:0] ST_IDLE    = 4'd0;
  localparam logic [ST_W-1:0] ST_GAIN_P  = 4'd1;
  localparam logic [ST_W-1:0] ST_GAIN_R  = 4'd2;
  localparam logic [ST_W-1:0] ST_SUM_R   = 4'd3;
  localparam logic [ST_W-1:0] ST_COR_P   = 4'd4;
  localparam logic [ST_W-1:0] ST_BLEND_P = 4'd5;
  localparam logic [ST_W-1:0] ST_COR_R   = 4'd6;
  localparam logic [ST_W-1:0] ST_BLEND_R = 4'd7;
  localparam logic [ST_W-1:0] ST_WRAP_P1 = 4'd8;
  localparam logic [ST_W-1:0] ST_WRAP_P2 = 4'd9;
  localparam logic [ST_W-1:0] ST_WRAP_R2 = 4'd10;

  logic [ST_W-1:0] state_q, state_d;

  // Configuration registers
  logic [DZ_W-1:0]     dz_pitch_q, dz_roll_q;
  logic [GAIN_W-1:0]   gain_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [FORCE_W-1:0]  force_low_q, force_high_q;

  // Captured sample
  logic signed [SAMPLE_W-1:0] ax_q, ay_q, az_q, gx_q, gz_q;
  logic signed [SAMPLE_W-1:0] gx_d, gz_d;
  logic                       applied_q, applied_d;

  // Angles
  logic signed [ANGLE_W-1:0] pitch_q, pitch_d, roll_q, roll_d;
  logic signed [WORK_W-1:0]  work_p_q, work_p_d, work_r_q, work_r_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic signed [ANGLE_W-1:0] out_pitch_q, out_roll_q;
  logic                      out_applied_q;
  logic                      out_load;

  // Shared units
  logic                      mul_en;
  logic signed [WORK_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [WORK_W-1:0]  blend_step;
  logic signed [MUL_B_W-1:0] weight_eff;
  cor_req_t                  cor_req;
  logic                      cor_done;
  logic signed [ANGLE_W-1:0] cor_angle;
  logic                      wrap_load;
  logic signed [WORK_W-1:0]  wrap_a;
  logic signed [ANGLE_W-1:0] wrap_res;

  logic [SUM_W-1:0] force_sum;
  logic             in_fire;

  assign in_fire     = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_pitch_q   <= RST_DZ_PITCH;
      dz_roll_q    <= RST_DZ_ROLL;
      gain_q       <= RST_GYRO_GAIN;
      weight_q     <= RST_ACC_WEIGHT;
      force_low_q  <= RST_FORCE_LOW;
      force_high_q <= RST_FORCE_HIGH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DZ_PITCH:   dz_pitch_q   <= cfg_data_i[DZ_W-1:0];
        CFG_DZ_ROLL:    dz_roll_q    <= cfg_data_i[DZ_W-1:0];
        CFG_GYRO_GAIN:  gain_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_ACC_WEIGHT: weight_q     <= cfg_data_i[WEIGHT_W-1:0];
        CFG_FORCE_LOW:  force_low_q  <= cfg_data_i[FORCE_W-1:0];
        CFG_FORCE_HIGH: force_high_q <= cfg_data_i[FORCE_W-1:0];
        default: ;
      endcase
    end
  end

  // Deadzone each gyro rate on capture
  always_comb begin
    gx_d = (mag_of(gyro_x_i) < {2'b00, dz_pitch_q}) ? '0 : gyro_x_i;
    gz_d = (mag_of(gyro_z_i) < {2'b00, dz_roll_q})  ? '0 : gyro_z_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= gx_d;
      gz_q <= gz_d;
    end
  end

  // Acceleration L1 magnitude and the correction weight, clamped to one
  assign force_sum = SUM_W'(mag_of(ax_q)) + SUM_W'(mag_of(ay_q)) + SUM_W'(mag_of(az_q));
  assign weight_eff = (weight_q > WEIGHT_ONE) ? MUL_B_W'(WEIGHT_ONE)
                                              : $signed({1'b0, weight_q});

  // Rounded blend increment from the registered product
  assign blend_step = WORK_W'((prod + PROD_W'(BLEND_RND)) >>> WEIGHT_FRAC);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    applied_d   = applied_q;
    work_p_d    = work_p_q;
    work_r_d    = work_r_q;
    pitch_d     = pitch_q;
    roll_d      = roll_q;
    mul_en      = 1'b0;
    mul_a       = WORK_W'(gx_q);
    mul_b       = $signed({2'b00, gain_q});
    cor_req     = '{start: 1'b0, y: ay_q, x: az_q};
    wrap_load   = 1'b0;
    wrap_a      = work_p_q;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_GAIN_P;
        end
      end
      ST_GAIN_P: begin
        mul_en    = 1'b1;
        applied_d = (force_sum > {1'b0, force_low_q}) && (force_sum < {1'b0, force_high_q});
        state_d   = ST_GAIN_R;
      end
      ST_GAIN_R: begin
        work_p_d = WORK_W'(pitch_q) + WORK_W'(prod);
        mul_en   = 1'b1;
        mul_a    = WORK_W'(gz_q);
        state_d  = ST_SUM_R;
      end
      ST_SUM_R: begin
        work_r_d      = WORK_W'(roll_q) - WORK_W'(prod);
        cor_req.start = applied_q;
        state_d       = applied_q ? ST_COR_P : ST_WRAP_P1;
      end
      ST_COR_P: begin
        // Issue the pitch blend and start the roll atan2 together
        if (cor_done) begin
          mul_en        = 1'b1;
          mul_a         = WORK_W'(cor_angle) - work_p_q;
          mul_b         = weight_eff;
          cor_req.start = 1'b1;
          cor_req.y     = ax_q;
          state_d       = ST_BLEND_P;
        end
      end
      ST_BLEND_P: begin
        work_p_d = work_p_q + blend_step;
        state_d  = ST_COR_R;
      end
      ST_COR_R: begin
        if (cor_done) begin
          mul_en  = 1'b1;
          mul_a   = WORK_W'(cor_angle) - work_r_q;
          mul_b   = weight_eff;
          state_d = ST_BLEND_R;
        end
      end
      ST_BLEND_R: begin
        work_r_d = work_r_q + blend_step;
        state_d  = ST_WRAP_P1;
      end
      ST_WRAP_P1: begin
        wrap_load = 1'b1;
        state_d   = ST_WRAP_P2;
      end
      ST_WRAP_P2: begin
        pitch_d   = wrap_res;
        wrap_load = 1'b1;
        wrap_a    = work_r_q;
        state_d   = ST_WRAP_R2;
      end
      ST_WRAP_R2: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          roll_d   = wrap_res;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop once the transaction completes
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      applied_q   <= 1'b0;
      pitch_q     <= '0;
      roll_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      applied_q   <= applied_d;
      pitch_q     <= pitch_d;
      roll_q      <= roll_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working angles and output payload
  always_ff @(posedge clk_i) begin
    work_p_q <= work_p_d;
    work_r_q <= work_r_d;
    if (out_load) begin
      out_pitch_q   <= pitch_q;
      out_roll_q    <= wrap_res;
      out_applied_q <= applied_q;
    end
  end

  ctf_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ctf_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cor_req),
    .done_o  (cor_done),
    .angle_o (cor_angle)
  );

  ctf_wrap u_wrap (
    .clk_i  (clk_i),
    .load_i (wrap_load),
    .a_i    (wrap_a),
    .res_o  (wrap_res)
  );

  assign out_valid_o     = out_valid_q;
  assign pitch_out_o     = out_pitch_q;
  assign roll_out_o      = out_roll_q;
  assign accel_applied_o = out_applied_q;

endmodule

[tb/complementary_tilt_filter_top_test.sv]
// Self-checking testbench of the complementary tilt filter top level.
// Depends on ctf_pkg and complementary_tilt_filter_top; carries its own
// bit-accurate tilt model that predicts every output transaction.
module complementary_tilt_filter_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ctf_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned PRINT_LIMIT = 40;

  // Indexes past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  // Tilt model constants
  localparam int     ATAN_FRAC    = 20;
  localparam int     ANGLE_SHIFT  = ATAN_FRAC - ANGLE_FRAC_BITS;
  localparam int     CORDIC_TURNS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam longint PRESCALE     = 16384;
  localparam longint UNITY        = 65536;
  localparam longint QUARTER_TURN = longint'(90) << ATAN_FRAC;
  localparam longint DEG_HALF     = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint DEG_FULL     = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint ATAN_STEP [24] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
    logic                      applied;
  } tilt_t;

  // Raw register data, possibly wider than the register it lands in
  typedef struct packed {
    logic [CFG_DATA_W-1:0] dz_pitch;
    logic [CFG_DATA_W-1:0] dz_roll;
    logic [CFG_DATA_W-1:0] gain;
    logic [CFG_DATA_W-1:0] weight;
    logic [CFG_DATA_W-1:0] low;
    logic [CFG_DATA_W-1:0] high;
  } setting_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_data_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [SAMPLE_W-1:0] accel_x_i;
  logic signed [SAMPLE_W-1:0] accel_y_i;
  logic signed [SAMPLE_W-1:0] accel_z_i;
  logic signed [SAMPLE_W-1:0] gyro_x_i;
  logic signed [SAMPLE_W-1:0] gyro_z_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [ANGLE_W-1:0]  pitch_out_o;
  logic signed [ANGLE_W-1:0]  roll_out_o;
  logic                       accel_applied_o;

  // Model registers and angle state
  longint dz_pitch = 10;
  longint dz_roll  = 25;
  longint gain     = 152;
  longint weight   = 1311;
  longint f_low    = 8192;
  longint f_high   = 32768;
  longint m_pitch  = 0;
  longint m_roll   = 0;

  tilt_t       pending_tilt [$];
  bit          idling      = 1'b1;
  int unsigned n_errors    = 0;
  int unsigned n_samples   = 0;
  int unsigned n_results   = 0;
  int unsigned n_corrected = 0;
  int unsigned n_settings  = 1;

  complementary_tilt_filter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .accel_x_i       (accel_x_i),
    .accel_y_i       (accel_y_i),
    .accel_z_i       (accel_z_i),
    .gyro_x_i        (gyro_x_i),
    .gyro_z_i        (gyro_z_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pitch_out_o     (pitch_out_o),
    .roll_out_o      (roll_out_o),
    .accel_applied_o (accel_applied_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint abs_of(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Vectoring CORDIC atan2 in angle units, floor shifts throughout
  function automatic longint tilt_atan2(input longint yv, input longint xv);
    longint x, y, t, nx, ny, acc;
    x   = xv * PRESCALE;
    y   = yv * PRESCALE;
    acc = 0;
    if (x == 0 && y == 0) return 0;
    // fold the left half-plane onto the right one
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x   = y;
        y   = -t;
        acc = QUARTER_TURN;
      end else begin
        x   = -y;
        y   = t;
        acc = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < CORDIC_TURNS; i++) begin
      if (y > 0) begin
        nx  = x + (y >>> i);
        ny  = y - (x >>> i);
        acc = acc + ATAN_STEP[i];
      end else begin
        nx  = x - (y >>> i);
        ny  = y + (x >>> i);
        acc = acc - ATAN_STEP[i];
      end
      x = nx;
      y = ny;
    end
    return (acc + (longint'(1) << (ANGLE_SHIFT - 1))) >>> ANGLE_SHIFT;
  endfunction

  function automatic longint mix_angle(input longint gyro_ang, input longint acc_ang,
                                       input longint w);
    return (gyro_ang * (UNITY - w) + acc_ang * w + (UNITY >>> 1)) >>> 16;
  endfunction

  function automatic longint wrap_deg(input longint a);
    longint r;
    r = (a + DEG_HALF) % DEG_FULL;
    if (r < 0) r = r + DEG_FULL;
    return r - DEG_HALF;
  endfunction

  // Advance the tilt state by one sample and return the expected transaction
  function automatic tilt_t next_tilt(input longint ax, input longint ay, input longint az,
                                      input longint gx, input longint gz);
    tilt_t  t;
    longint p, r, w, mag;
    logic   hit;
    w = (weight > UNITY) ? UNITY : weight;
    if (abs_of(gx) < dz_pitch) gx = 0;
    if (abs_of(gz) < dz_roll) gz = 0;
    p   = m_pitch + gx * gain;
    r   = m_roll - gz * gain;
    mag = abs_of(ax) + abs_of(ay) + abs_of(az);
    hit = (mag > f_low) && (mag < f_high);
    if (hit) begin
      p = mix_angle(p, tilt_atan2(ay, az), w);
      r = mix_angle(r, tilt_atan2(ax, az), w);
      n_corrected++;
    end
    m_pitch   = wrap_deg(p);
    m_roll    = wrap_deg(r);
    t.pitch   = m_pitch[ANGLE_W-1:0];
    t.roll    = m_roll[ANGLE_W-1:0];
    t.applied = hit;
    return t;
  endfunction

  task automatic report_error(input string msg);
    n_errors++;
    if (n_errors <= PRINT_LIMIT) $display("%0t: %s", $realtime, msg);
  endtask

  // Send one sample; valid is left high so that the next one follows back to back
  task automatic send_imu(input int ax, input int ay, input int az, input int gx, input int gz);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    accel_x_i  <= 16'(ax);
    accel_y_i  <= 16'(ay);
    accel_z_i  <= 16'(az);
    gyro_x_i   <= 16'(gx);
    gyro_z_i   <= 16'(gz);
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_tilt.insert(pending_tilt.size(), next_tilt(ax, ay, az, gx, gz));
    n_samples++;
  endtask

  // Drop the input valid and hold until every result has been taken
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_tilt.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      CFG_DZ_PITCH:   dz_pitch = longint'(data[DZ_W-1:0]);
      CFG_DZ_ROLL:    dz_roll  = longint'(data[DZ_W-1:0]);
      CFG_GYRO_GAIN:  gain     = longint'(data[GAIN_W-1:0]);
      CFG_ACC_WEIGHT: weight   = longint'(data[WEIGHT_W-1:0]);
      CFG_FORCE_LOW:  f_low    = longint'(data[FORCE_W-1:0]);
      CFG_FORCE_HIGH: f_high   = longint'(data[FORCE_W-1:0]);
      default: ;
    endcase
  endtask

  // Write all six registers once the block is idle, then the spare indexes if asked
  task automatic load_setting(input setting_t s, input bit spares);
    wait_idle();
    cfg_write(CFG_DZ_PITCH, s.dz_pitch);
    cfg_write(CFG_DZ_ROLL, s.dz_roll);
    cfg_write(CFG_GYRO_GAIN, s.gain);
    cfg_write(CFG_ACC_WEIGHT, s.weight);
    cfg_write(CFG_FORCE_LOW, s.low);
    cfg_write(CFG_FORCE_HIGH, s.high);
    if (spares) begin
      cfg_write(CFG_SPARE_6, 17'($urandom));
      cfg_write(CFG_SPARE_7, 17'($urandom));
    end
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  function automatic int signed_near(input int unsigned m);
    return int'($urandom_range(0, 2 * m)) - int'(m);
  endfunction

  function automatic int raw16();
    return int'($signed(16'($urandom)));
  endfunction

  // Gyro rate: mostly around the deadzone edge, now and then full range
  function automatic int rate_near(input longint dz);
    longint m;
    m = dz + dz / 2 + 2;
    if (m > 32767) m = 32767;
    return ($urandom_range(0, 3) == 0) ? raw16() : signed_near(int'(m));
  endfunction

  task automatic send_random();
    int          ax, ay, az;
    int unsigned shape;
    shape = $urandom_range(0, 9);
    if (shape < 6) begin
      // gravity-like vector, lands in the default force window often
      ax = signed_near(9000);
      ay = signed_near(9000);
      az = signed_near(20000);
    end else if (shape < 8) begin
      ax = raw16();
      ay = raw16();
      az = raw16();
    end else if (shape == 8) begin
      // on the z axis, including straight down
      ax = 0;
      ay = 0;
      az = raw16();
    end else begin
      ax = ($urandom_range(0, 7) == 0) ? 0 : raw16();
      ay = ($urandom_range(0, 7) == 0) ? 0 : raw16();
      az = 0;
    end
    send_imu(ax, ay, az, rate_near(dz_pitch), rate_near(dz_roll));
  endtask

  // Reset registers: zero vector, window edges, deadzone edges, sample extremes
  task automatic test_directed_extremes();
    send_imu(0, 0, 0, 0, 0);
    send_imu(0, 0, 8192, 10, 25);
    send_imu(0, 0, 8193, 9, 24);
    send_imu(0, 0, -16384, -10, -25);
    send_imu(0, 16384, 0, -9, -24);
    send_imu(0, -16384, 0, 11, 26);
    send_imu(3000, -5000, -10000, 100, -100);
    send_imu(10000, 10000, 12767, -32768, 32767);
    send_imu(1, 0, 32767, 32767, -32768);
    send_imu(-32768, -32768, -32768, -32768, -32768);
    send_imu(32767, 32767, 32767, 32767, 32767);
    send_imu(-9000, 4000, -9000, 1234, -4321);
  endtask

  // Masking of wide data, spare indexes, weight above one, empty window
  task automatic test_register_edges();
    setting_t s;
    s = '{17'h1FFFF, 17'd0, 17'hFFFF, 17'h1FFFF, 17'd0, 17'd98304};
    load_setting(s, 1'b1);
    send_imu(0, 0, 16384, 32766, 1);
    send_imu(0, 0, -16384, 32767, -1);
    send_imu(-32768, -32768, -32768, -32768, 0);
    send_imu(-32768, 32767, 1, 0, 32767);
    s = '{17'd0, 17'd0, 17'd0, 17'd0, 17'd40000, 17'd40000};
    load_setting(s, 1'b0);
    send_imu(20000, 0, 20000, 500, 500);
    send_imu(20001, 0, 20000, -500, -500);
    send_imu(-5000, 3000, 2000, 32767, -32768);
    s = '{17'd5, 17'd5, 17'd700, 17'd65536, 17'd98302, 17'd98304};
    load_setting(s, 1'b0);
    send_imu(-32768, -32768, 32767, 6, -6);
    send_imu(-32768, -32768, -32768, 4, 5);
  endtask

  // Random samples across default, extreme, mid and random register settings
  task automatic test_random_settings();
    setting_t    plan [6];
    int unsigned lo;
    lo = $urandom_range(0, 40000);
    plan[0] = '{17'd10, 17'd25, 17'd152, 17'd1311, 17'd8192, 17'd32768};
    plan[1] = '{17'd0, 17'd0, 17'd65535, 17'd65536, 17'd0, 17'd98304};
    plan[2] = '{17'd32767, 17'd32767, 17'd1, 17'd0, 17'd8192, 17'd32768};
    plan[3] = '{17'd100, 17'd3000, 17'd2000, 17'd30000, 17'd20000, 17'd60000};
    plan[4] = '{17'($urandom_range(0, 400)), 17'($urandom_range(0, 400)), 17'($urandom),
                17'($urandom), 17'(lo), 17'(lo + $urandom_range(0, 40000))};
    plan[5] = plan[0];
    for (int k = 0; k < 6; k++) begin
      // last stretch runs without idling on either side
      if (k == 5) idling = 1'b0;
      load_setting(plan[k], 1'b0);
      repeat (PHASE_ITEMS) send_random();
    end
  endtask

  // Output stalls in random bursts
  initial begin : drive_out_ready
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0 && idling && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 14);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    tilt_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      n_results++;
      if (pending_tilt.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing pending", n_results));
      end else begin
        want = pending_tilt.pop_front();
        if (pitch_out_o !== want.pitch)
          report_error($sformatf("result %0d pitch %0d, predicted %0d",
                                 n_results, pitch_out_o, want.pitch));
        if (roll_out_o !== want.roll)
          report_error($sformatf("result %0d roll %0d, predicted %0d",
                                 n_results, roll_out_o, want.roll));
        if (accel_applied_o !== want.applied)
          report_error($sformatf("result %0d correction flag %b, predicted %b",
                                 n_results, accel_applied_o, want.applied));
      end
    end
  end

  // End the run when no channel has moved a transaction for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("timeout after %0d quiet cycles", IDLE_LIMIT);
    $display("complementary_tilt_filter_top_test: errors");
    $finish;
  end

  initial begin : run
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    accel_x_i   <= '0;
    accel_y_i   <= '0;
    accel_z_i   <= '0;
    gyro_x_i    <= '0;
    gyro_z_i    <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_register_edges();
    test_random_settings();
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("covered %0d samples (%0d with accelerometer correction) over %0d settings",
             n_samples, n_corrected, n_settings);
    $display("checked %0d results, %0d mismatches", n_results, n_errors);
    if (n_errors == 0)
      $display("complementary_tilt_filter_top_test: clean");
    else
      $display("complementary_tilt_filter_top_test: errors");
    $finish;
  end

endmodule

[filelist.f]
hdl/ctf_pkg.sv
hdl/ctf_mul.sv
hdl/ctf_cordic.sv
hdl/ctf_wrap.sv
hdl/complementary_tilt_filter_top.sv
tb/complementary_tilt_filter_top_test.sv
